// File: hw/rtl/uor_pkg.sv
`default_nettype none

package uor_pkg;

    localparam int TIMER_W    = 16;
    localparam int DIST_W     = 11;
    localparam int HIT_W      = 8;
    localparam int SUB_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam int TIMER_BITS    = 16;
    localparam int GAP_TICKS     = 250;
    localparam int TRIGGER_TICKS = 20;
    localparam int TICKS_PER_CM  = 58;
    localparam int CM_RAW        = ((1 << TIMER_BITS) - 1) / TICKS_PER_CM;
    localparam int CM_MAX        = (CM_RAW > 2047) ? 2047 : CM_RAW;
    localparam int HIT_MAX       = (1 << HIT_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HITS_NEEDED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TMO    = 2'd2;

    localparam logic [DIST_W-1:0]  MAX_RANGE_RST   = 11'd50;
    localparam logic [HIT_W-1:0]   HITS_NEEDED_RST = 8'd3;
    localparam logic [TIMER_W-1:0] ECHO_TMO_RST    = 16'd30000;

    typedef enum logic [1:0] {
        PH_GAP,
        PH_TRIG,
        PH_RISE,
        PH_MEAS
    } phase_t;

    typedef struct packed {
        logic [DIST_W-1:0]  max_range_cm;
        logic [HIT_W-1:0]   hits_needed;
        logic [TIMER_W-1:0] echo_start_timeout;
    } uor_cfg_t;

    typedef struct packed {
        logic              measure_done;
        logic              obstacle;
        logic [DIST_W-1:0] distance_cm;
        logic              trigger_level;
    } uor_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/uor_cfg.sv
`default_nettype none

module uor_cfg
    import uor_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output uor_cfg_t                   cfg
);

    uor_cfg_t cfg_reg;
    uor_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_RANGE:   cfg_next.max_range_cm       = cfg_data[DIST_W-1:0];
                REG_HITS_NEEDED: cfg_next.hits_needed        = cfg_data[HIT_W-1:0];
                REG_ECHO_TMO:    cfg_next.echo_start_timeout = cfg_data[TIMER_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_range_cm       <= MAX_RANGE_RST;
            cfg_reg.hits_needed        <= HITS_NEEDED_RST;
            cfg_reg.echo_start_timeout <= ECHO_TMO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/uor_core.sv
`default_nettype none

module uor_core
    import uor_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic echo,
    input  wire logic enable,
    input  wire uor_cfg_t cfg,
    output uor_result_t result
);

    phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [DIST_W-1:0]   cm_reg, cm_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [DIST_W-1:0]   last_reg, last_next;
    logic [HIT_W-1:0]    hit_reg, hit_next;
    logic                flag_reg, flag_next;

    logic [TIMER_W:0]    timer_inc;
    logic [SUB_W-1:0]    sub_inc;
    logic                sub_wrap;
    logic                rise_timeout;
    logic                done;
    logic                trig;
    logic [DIST_W-1:0]   finish_dist;
    logic [HIT_W-1:0]    hit_bumped;

    assign timer_inc    = {1'b0, timer_reg} + 1'b1;
    assign sub_inc      = sub_reg + 1'b1;
    assign sub_wrap     = (sub_inc >= SUB_W'(TICKS_PER_CM));
    assign rise_timeout = (timer_inc >= {1'b0, cfg.echo_start_timeout});
    assign done         = enable && (((phase_reg == PH_RISE) && !echo && rise_timeout)
                                  || ((phase_reg == PH_MEAS) && !echo));
    assign finish_dist  = (phase_reg == PH_MEAS) ? cm_reg : '0;
    assign hit_bumped   = (hit_reg == HIT_W'(HIT_MAX)) ? hit_reg : hit_reg + 1'b1;

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        if (!enable)
        begin
            phase_next = PH_GAP;
            timer_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_TRIG:
                begin
                    if (timer_inc >= (TIMER_W+1)'(TRIGGER_TICKS))
                    begin
                        phase_next = PH_RISE;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc[TIMER_W-1:0];
                    end
                end
                PH_RISE:
                begin
                    if (echo)
                    begin
                        phase_next = PH_MEAS;
                        timer_next = '0;
                    end
                    else if (rise_timeout)
                    begin
                        phase_next = PH_GAP;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc[TIMER_W-1:0];
                    end
                end
                PH_MEAS:
                begin
                    if (!echo)
                    begin
                        phase_next = PH_GAP;
                        timer_next = '0;
                    end
                end
                default:
                begin
                    if (timer_inc >= (TIMER_W+1)'(GAP_TICKS))
                    begin
                        phase_next = PH_TRIG;
                        timer_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                        timer_next = timer_inc[TIMER_W-1:0];
                    end
                end
            endcase
        end
    end

    // width count, hit count and result
    always_comb
    begin
        cm_next   = cm_reg;
        sub_next  = sub_reg;
        last_next = last_reg;
        hit_next  = hit_reg;
        flag_next = flag_reg;
        trig      = 1'b0;
        if (!enable)
        begin
            cm_next  = '0;
            sub_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_TRIG:
                begin
                    trig = 1'b1;
                end
                PH_RISE:
                begin
                    if (echo)
                    begin
                        cm_next  = '0;
                        sub_next = SUB_W'(1);
                    end
                    else if (rise_timeout)
                    begin
                        cm_next  = '0;
                        sub_next = '0;
                    end
                end
                PH_MEAS:
                begin
                    if (echo)
                    begin
                        if (sub_wrap)
                        begin
                            sub_next = '0;
                            if (cm_reg != DIST_W'(CM_MAX))
                            begin
                                cm_next = cm_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sub_next = sub_inc;
                        end
                    end
                    else
                    begin
                        cm_next  = '0;
                        sub_next = '0;
                    end
                end
                default:
                begin
                    trig = 1'b0;
                end
            endcase
        end

        if (done)
        begin
            last_next = finish_dist;
            if (finish_dist != '0)
            begin
                if (finish_dist <= cfg.max_range_cm)
                begin
                    hit_next = hit_bumped;
                    if (hit_bumped >= cfg.hits_needed)
                    begin
                        flag_next = 1'b1;
                    end
                end
                else
                begin
                    hit_next  = '0;
                    flag_next = 1'b0;
                end
            end
        end

        result.trigger_level = trig;
        result.distance_cm   = last_next;
        result.obstacle      = flag_next;
        result.measure_done  = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_GAP;
            timer_reg <= '0;
            cm_reg    <= '0;
            sub_reg   <= '0;
            last_reg  <= '0;
            hit_reg   <= '0;
            flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            cm_reg    <= cm_next;
            sub_reg   <= sub_next;
            last_reg  <= last_next;
            hit_reg   <= hit_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ultrasonic_obstacle_ranger.sv
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    echo and enable, one request per tick
// m_*       out        m_tvalid / m_tready    trigger, distance, obstacle, done
// cfg_*     in         cfg_valid / cfg_ready  register index and write data
//
// One request per cycle sustained while m_tready is high; a request's result passes
// through the input register, then the result register.
// Each request steps the ranging phase machine once; one update per cycle while unstalled.
// Reset (rst_n low, asynchronous) returns to the idle gap with counts cleared.
// A stalled result holds in the result register; the input register still takes
// one request, then holds it until the stall clears.
`default_nettype none

module ultrasonic_obstacle_ranger
    import uor_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [0] echo_level, [1] enable
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [0] trigger_level, [11:1] distance_cm,
                                                  // [12] obstacle, [13] measure_done
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    uor_cfg_t    cfg;
    uor_result_t result;

    logic        in_valid_reg, in_valid_next;
    logic        in_echo_reg;
    logic        in_enable_reg;
    logic        out_valid_reg, out_valid_next;
    uor_result_t out_reg;
    logic        s_accept;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    uor_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uor_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .echo   (in_echo_reg),
        .enable (in_enable_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_echo_reg   <= 1'b0;
            in_enable_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_echo_reg   <= s_tdata[0];
            in_enable_reg <= s_tdata[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.measure_done, out_reg.obstacle,
                       out_reg.distance_cm, out_reg.trigger_level};

    a_done_no_trig: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(result.measure_done && result.trigger_level))
        else $error("measurement completes on a trigger tick");

    a_flag_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result.obstacle != out_reg.obstacle)) |-> result.measure_done)
        else $error("obstacle flag changed without a completed measurement");

    a_dist_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result.distance_cm != out_reg.distance_cm)) |-> result.measure_done)
        else $error("distance changed without a completed measurement");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_echo_reg)
                                        && $stable(in_enable_reg)))
        else $error("held request lost or overwritten");

    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_enable_reg) |-> (!result.trigger_level && !result.measure_done))
        else $error("activity while disabled");

endmodule

`default_nettype wire
